// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/iida_pkg.sv =====
// ---------------------------------------------------------------------------
// Indexed insert/delete array package
// Command and status codes and the control bundle broadcast to the cells.
// ---------------------------------------------------------------------------
package iida_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_GET    = 3'd3,
    OP_SET    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  localparam int WORD_W = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  // Row-wide control for one accepted request.
  typedef struct packed {
    logic ins;  // shift up from the target index, load the new word there
    logic rem;  // shift down from the target index
    logic wr;   // overwrite the word at the target index
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/indexed_insert_delete_array.sv =====
// ---------------------------------------------------------------------------
// Indexed insert/delete array
// Ordered array of signed words with fixed capacity, held in a row of cells.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on s_tvalid/s_tready/s_tdata: func (append, insert,
//   remove, get, set), position and element. Each request yields one result
//   on m_tvalid/m_tready/m_tdata: status, read_value and the count after it.
//   m_tvalid rises in the cycle after acceptance; one request per cycle
//   is sustained while m_tready stays high. Every cell compares the broadcast
//   index with its own and shifts, loads or holds in that same cycle, and the
//   addressed cell drives an OR bus that is captured in the output register.
//   The result register sits between the sides: s_tready is high while that
//   register is empty or being taken, so a stalled receiver holds the result
//   and s_tready stays low until the result is taken.
//   Reset clears the count and the output valid; cell contents are left as
//   they are and are never read before being written.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_insert_delete_array #(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst,
  // s_tdata: func[2:0], position[CW-1:0], element[31:0], zero fill
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  input  logic [((3+$clog2(CAPACITY+1)+32+7)/8)*8-1:0] s_tdata,
  // m_tdata: status[1:0], read_value[31:0], count[CW-1:0], zero fill
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [((2+32+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata
);
  import iida_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IN_W  = ((OP_W + CW + WORD_W + 7) / 8) * 8;
  localparam int OUT_W = ((STAT_W + WORD_W + CW + 7) / 8) * 8;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic               fire;
  op_t                func;
  logic [CW-1:0]      position;
  logic signed [31:0] element;

  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_next;
  status_t            status;
  logic signed [31:0] read_value;
  logic [CW-1:0]      cell_pos;
  cell_ctrl_t         ctrl;
  logic signed [31:0] rd_or;

  logic signed [31:0] words [CAPACITY];
  logic signed [31:0] rds   [CAPACITY];

  status_t            out_status;
  logic signed [31:0] out_read;
  logic [CW-1:0]      out_count;

  logic               append_go;

  assign func     = op_t'(s_tdata[OP_W-1:0]);
  assign position = s_tdata[OP_W +: CW];
  assign element  = s_tdata[OP_W+CW +: WORD_W];

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;

  // Decode one request against the current count.
  always_comb begin
    status     = ST_OK;
    read_value = '0;
    cnt_next   = cnt;
    cell_pos   = position;
    ctrl       = '0;
    case (func)
      OP_APPEND: begin
        cell_pos = cnt;
        if (cnt == CAP) begin
          status = ST_FULL;
        end else begin
          ctrl.wr  = fire;
          cnt_next = cnt + 1'b1;
        end
      end
      OP_INSERT: begin
        if (position > cnt) begin
          status = ST_BAD_INDEX;
        end else if (cnt == CAP) begin
          status = ST_FULL;
        end else begin
          ctrl.ins = fire;
          cnt_next = cnt + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (position >= cnt) begin
          status = ST_BAD_INDEX;
        end else begin
          ctrl.rem = fire;
          cnt_next = cnt - 1'b1;
        end
      end
      OP_GET: begin
        if (position >= cnt) begin
          status     = ST_BAD_INDEX;
          read_value = '1;
        end else begin
          read_value = rd_or;
        end
      end
      OP_SET: begin
        if (position >= cnt) begin
          status = ST_BAD_INDEX;
        end else begin
          ctrl.wr = fire;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_w;
    logic signed [31:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = words[i];
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    iida_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .pos   (cell_pos),
      .elem  (element),
      .left  (left_w),
      .right (right_w),
      .word  (words[i]),
      .rd    (rds[i])
    );
  end

  // At most one cell drives a nonzero word onto the read bus.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rds[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        cnt      <= cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= status;
      out_read   <= read_value;
      out_count  <= cnt_next;
    end
  end

  assign m_tdata = {{(OUT_W-STAT_W-WORD_W-CW){1'b0}}, out_count, out_read, out_status};

  logic [IN_W-1:0] in_unused;
  assign in_unused = s_tdata;

  assign append_go = fire && (func == OP_APPEND) && (cnt != CAP);

  `ASSERT_ALWAYS(a_cnt_bound, cnt <= CAP, "count exceeds capacity")
  `ASSERT_ALWAYS(a_out_count, !m_tvalid || (out_count == cnt), "result count differs from state")
  `ASSERT_NEXT(a_append_grows, append_go, cnt == $past(cnt) + 1'b1, "append did not grow count")
  `ASSERT_NEXT(a_idle_holds, !fire, cnt == $past(cnt), "count moved without a request")

endmodule

// ===== hw/rtl/iida_cell.sv =====
// ---------------------------------------------------------------------------
// Array cell
// Holds one word; loads from its lower or upper neighbor or the new word.
// ---------------------------------------------------------------------------
module iida_cell #(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  iida_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]        pos,
  input  logic signed [31:0]   elem,
  input  logic signed [31:0]   left,
  input  logic signed [31:0]   right,
  output logic signed [31:0]   word,
  output logic signed [31:0]   rd
);
  import iida_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic hit;
  logic above;

  assign hit   = (pos == MY_IDX);
  assign above = (MY_IDX > pos);

  always_ff @(posedge clk) begin
    if (ctrl.ins && above) begin
      word <= left;
    end else if ((ctrl.ins || ctrl.wr) && hit) begin
      word <= elem;
    end else if (ctrl.rem && (above || hit)) begin
      word <= right;
    end
  end

  // Drive the word onto the read bus only when addressed.
  assign rd = hit ? word : '0;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert/delete array testbench
// Drives append, insert, remove, get, set and unknown requests into the
// array and compares every result with a behavioral copy kept here.
// ----------------------------------------------------------------------------
module testbench;
  import iida_pkg::*;

  localparam int CAP   = 64;
  localparam int S_W   = 48;
  localparam int M_W   = 48;
  localparam int LIMIT = 200000;
  localparam int PHASE_ITEMS = 460;

  typedef struct {
    logic [2:0]  func;
    logic [6:0]  pos;
    logic [31:0] word;
  } cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic [6:0]  len;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // func[2:0], position[9:3], element[41:10], zero fill
  logic [S_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // status[1:0], read_value[33:2], count[40:34], zero fill
  logic [M_W-1:0] m_tdata;

  cmd_t   cmd_queue[$];
  reply_t result_due[$];

  // Array contents as the block should hold them.
  logic [31:0] shadow_words[CAP];
  int          shadow_len = 0;

  // Length tracked while building the stimulus, ahead of the run.
  int gen_len = 0;
  int gen_total = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int accepted_cnt = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int err_cnt = 0;
  int cycles = 0;
  cmd_t drive_cmd;

  indexed_insert_delete_array #(.CAPACITY(CAP)) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles == LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  function automatic reply_t apply_command(cmd_t c);
    reply_t r;
    int k;
    r.status = ST_OK;
    r.value  = '0;
    case (c.func)
      OP_APPEND: begin
        if (shadow_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_len] = c.word;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        if (c.pos > shadow_len) begin
          r.status = ST_BAD_INDEX;
        end else if (shadow_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (k = shadow_len; k > c.pos; k--) shadow_words[k] = shadow_words[k-1];
          shadow_words[c.pos] = c.word;
          shadow_len++;
        end
      end
      OP_REMOVE: begin
        if (c.pos >= shadow_len) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (k = c.pos; k + 1 < shadow_len; k++) shadow_words[k] = shadow_words[k+1];
          shadow_len--;
        end
      end
      OP_GET: begin
        if (c.pos >= shadow_len) begin
          r.status = ST_BAD_INDEX;
          r.value  = 32'hFFFF_FFFF;
        end else begin
          r.value = shadow_words[c.pos];
        end
      end
      OP_SET: begin
        if (c.pos >= shadow_len) r.status = ST_BAD_INDEX;
        else shadow_words[c.pos] = c.word;
      end
      default: ;
    endcase
    r.len = shadow_len[6:0];
    return r;
  endfunction

  // Queue a request and keep the stimulus-side length in step.
  function automatic void push_cmd(logic [2:0] func, int pos, logic [31:0] word);
    cmd_t c;
    c.func = func;
    c.pos  = pos[6:0];
    c.word = word;
    case (func)
      OP_APPEND: if (gen_len < CAP) gen_len++;
      OP_INSERT: if (pos <= gen_len && gen_len < CAP) gen_len++;
      OP_REMOVE: if (pos < gen_len) gen_len--;
      default: ;
    endcase
    cmd_queue.push_back(c);
    gen_total++;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_pos(logic [2:0] func);
    int top;
    top = (func == OP_INSERT) ? gen_len : gen_len - 1;
    if (top >= 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, top);
    return $urandom_range(top + 1, 127);
  endfunction

  function automatic void push_random();
    logic [2:0] func;
    int n;
    n = $urandom_range(0, 99);
    if (n < 3) func = 3'($urandom_range(5, 7));
    else if (n < 22) func = OP_APPEND;
    else if (n < 42) func = OP_INSERT;
    else if (n < 66) func = OP_REMOVE;
    else if (n < 84) func = OP_GET;
    else func = OP_SET;
    push_cmd(func, pick_pos(func), rand_word());
  endfunction

  // Grow to capacity, then try every refused growth, a get and a set.
  function automatic void push_fill();
    while (gen_len < CAP) begin
      if ($urandom_range(0, 1) == 0) push_cmd(OP_APPEND, $urandom_range(0, 127), rand_word());
      else push_cmd(OP_INSERT, $urandom_range(0, gen_len), rand_word());
    end
    push_cmd(OP_APPEND, $urandom_range(0, 127), rand_word());
    push_cmd(OP_INSERT, $urandom_range(0, CAP), rand_word());
    push_cmd(OP_INSERT, $urandom_range(CAP + 1, 127), rand_word());
    push_cmd(OP_GET, CAP - 1, rand_word());
    push_cmd(OP_SET, $urandom_range(0, CAP - 1), rand_word());
  endfunction

  function automatic void push_drain();
    while (gen_len > 0) push_cmd(OP_REMOVE, $urandom_range(0, gen_len - 1), rand_word());
    push_cmd(OP_GET, 0, rand_word());
    push_cmd(OP_REMOVE, 0, rand_word());
  endfunction

  function automatic void push_directed();
    push_cmd(OP_GET, 0, 32'h0);             // empty: bad index, reads -1
    push_cmd(OP_REMOVE, 0, 32'h0);
    push_cmd(OP_SET, 0, 32'h1234_5678);
    push_cmd(OP_INSERT, 1, 32'h1);          // past the end
    push_cmd(OP_APPEND, 127, 32'h7FFF_FFFF);
    push_cmd(OP_INSERT, 0, 32'h8000_0000);  // head
    push_cmd(OP_INSERT, 2, 32'hFFFF_FFFF);  // tail
    push_cmd(OP_INSERT, 1, 32'h0);          // middle
    push_cmd(OP_GET, 0, 32'h0);
    push_cmd(OP_GET, 3, 32'h0);
    push_cmd(OP_GET, 4, 32'h0);
    push_cmd(OP_SET, 3, 32'h5A5A_5A5A);
    push_cmd(OP_GET, 3, 32'hA5A5_A5A5);
    push_cmd(OP_REMOVE, 0, 32'h0);
    push_cmd(OP_REMOVE, 2, 32'h0);
    push_cmd(OP_GET, 127, 32'hFFFF_FFFF);
    push_cmd(3'd5, 0, 32'h0);               // unknown commands
    push_cmd(3'd6, 64, 32'h8000_0000);
    push_cmd(3'd7, 127, 32'hFFFF_FFFF);
    push_cmd(OP_INSERT, 127, 32'h1);
    push_cmd(OP_SET, 64, 32'h2);
    push_cmd(OP_GET, 1, 32'h0);
    push_cmd(OP_REMOVE, 1, 32'h0);
    push_cmd(OP_REMOVE, 0, 32'h0);
  endfunction

  // Sender: hold the request until taken, then maybe idle.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drive_cmd = cmd_queue.pop_front();
        s_tdata  <= {6'b0, drive_cmd.word, drive_cmd.pos, drive_cmd.func};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once, early in the run.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt == 60) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check results against the oldest prediction, predict new ones.
  always @(posedge clk) begin
    reply_t exp_r;
    cmd_t   acc;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        if (result_due.size() == 0) begin
          $display("%0t: result with none expected: status %0d value %0d count %0d",
                   $time, m_tdata[1:0], $signed(m_tdata[33:2]), m_tdata[40:34]);
          err_cnt++;
        end else begin
          exp_r = result_due.pop_front();
          if (m_tdata[1:0] !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     m_tdata[1:0]);
            err_cnt++;
          end
          if (m_tdata[33:2] !== exp_r.value) begin
            $display("%0t: read_value expected %0d actual %0d", $time,
                     $signed(exp_r.value), $signed(m_tdata[33:2]));
            err_cnt++;
          end
          if (m_tdata[40:34] !== exp_r.len) begin
            $display("%0t: count expected %0d actual %0d", $time, exp_r.len,
                     m_tdata[40:34]);
            err_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        acc.func = s_tdata[2:0];
        acc.pos  = s_tdata[9:3];
        acc.word = s_tdata[41:10];
        result_due.push_back(apply_command(acc));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  initial begin
    int ph;
    int goal;
    int pick;
    wait (!rst);
    for (ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (ph == 0) push_directed();
      goal = gen_total + PHASE_ITEMS;
      while (gen_total < goal) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          push_fill();
        end else if (pick == 2) begin
          push_drain();
        end else begin
          repeat ($urandom_range(20, 40)) push_random();
        end
      end
      wait (cmd_queue.size() == 0);
    end
    wait (!s_tvalid && result_due.size() == 0);
    repeat (5) @(posedge clk);
    if (err_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/iida_pkg.sv
hw/rtl/iida_cell.sv
hw/rtl/indexed_insert_delete_array.sv
bench/testbench.sv
